// ----- src/fvns_pkg.sv -----
// Shared types and constants for the four-voice note sequencer.
`default_nettype none
package fvns_pkg;
  localparam int SONG_BYTES = 8192;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic ITEM_NOTE   = 1'b0;
  localparam logic ITEM_STATUS = 1'b1;

  localparam logic [15:0] DUR_END = 16'hffff;

  // Datapath commands from the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_WRITE,      // store in_data at in_address
    CMD_RD_HDR,     // issue header byte read for byte index
    CMD_HDR_LO,     // capture offset low byte
    CMD_HDR_HI,     // capture offset high byte, set pointer
    CMD_RD_NOTE,    // issue note byte read
    CMD_CAP_NOTE,   // capture note byte idx
    CMD_MATH1,      // register products
    CMD_COMMIT      // update voice, build event
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] voice;
    logic [2:0] idx;
  } ctl_t;

  typedef struct packed {
    logic       done;   // selected voice ended
    logic       due;    // selected voice countdown <= 1
  } sts_t;
endpackage
`default_nettype wire

// ----- src/fvns_datapath.sv -----
// Song memory, per-voice state and note arithmetic.
`default_nettype none
module fvns_datapath
  import fvns_pkg::*;
#(
  parameter int VOICES     = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctl_t        ctl,
  input  wire logic        dec,       // decrement selected countdown
  input  wire logic        start,     // clear voice state
  input  wire logic [12:0] wr_addr,
  input  wire logic [7:0]  wr_data,
  output sts_t             sts,
  output logic [13:0]      tone,
  output logic [20:0]      length_ms,
  output logic [7:0]       volume,
  output logic             sounding,
  output logic             voice_ended
);
  localparam int AW = $clog2(SONG_BYTES);

  logic [7:0]    mem [SONG_BYTES];
  logic [7:0]    rdata_r;
  logic [AW-1:0] raddr;
  logic [AW-1:0] ptr_r  [4];
  logic [15:0]   cnt_r  [4];
  logic [3:0]    done_r;
  logic [7:0]    off_lo_r;
  logic [7:0]    nb_r [5];
  logic [20:0]   len_r;
  logic [15:0]   rel_r;
  logic [13:0]   tone_r;

  logic [15:0] dur;
  logic [9:0]  freq;
  logic [3:0]  att;
  assign dur  = {nb_r[1], nb_r[0]};
  assign freq = {nb_r[2][5:0], nb_r[3][3:0]};
  assign att  = nb_r[4][3:0];

  // Read address: header bytes or pointer plus byte index, modulo size.
  always_comb begin
    if (ctl.cmd == CMD_RD_HDR) raddr = AW'({ctl.voice, ctl.idx[0]});
    else raddr = ptr_r[ctl.voice] + AW'(ctl.idx);
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_WRITE && {3'b0, wr_addr} < 16'(SONG_BYTES))
      mem[wr_addr[AW-1:0]] <= wr_data;
    rdata_r <= mem[raddr];
  end

  // dur/3 = dur*43691 >> 17, exact for 16-bit dur; dur*10/28 = dur*5/14.
  logic [15:0] q3;
  logic [31:0] p3;
  assign p3 = 32'(dur) * 32'd43691;
  assign q3 = {1'b0, p3[31:17]};

  logic [19:0] d5;
  logic [39:0] p14;
  assign d5  = 20'(dur) * 20'd5;
  // x/14 for x < 2^19: x*599187 >> 23
  assign p14 = 40'(d5) * 40'd599187;

  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_HDR_LO) off_lo_r <= rdata_r;
    if (ctl.cmd == CMD_CAP_NOTE) nb_r[ctl.idx] <= rdata_r;
    if (ctl.cmd == CMD_MATH1) begin
      len_r  <= (dur == DUR_END) ? 21'd300 : 21'(q3) * 21'd50;
      rel_r  <= p14[38:23];
      tone_r <= 14'(freq) * 14'd10;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      for (int i = 0; i < 4; i++) begin
        ptr_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      if (start) begin
        for (int i = 0; i < 4; i++) begin
          cnt_r[i] <= '0;
          done_r[i] <= (i >= VOICES);
          if (i >= VOICES) ptr_r[i] <= '0;
        end
      end
      if (ctl.cmd == CMD_HDR_HI)
        ptr_r[ctl.voice] <= AW'({rdata_r, off_lo_r});
      if (dec) cnt_r[ctl.voice] <= cnt_r[ctl.voice] - 16'd1;
      if (ctl.cmd == CMD_COMMIT) begin
        cnt_r[ctl.voice] <= rel_r;
        ptr_r[ctl.voice] <= ptr_r[ctl.voice] + AW'(5);
        if (dur == DUR_END) done_r[ctl.voice] <= 1'b1;
      end
    end
  end

  assign sts.done    = done_r[ctl.voice];
  assign sts.due     = cnt_r[ctl.voice] <= 16'd1;
  assign tone        = tone_r;
  assign length_ms   = len_r;
  assign volume      = (att == 4'hf) ? 8'd0 : 8'hff - {3'b0, att, 1'b0};
  assign sounding    = freq != '0;
  assign voice_ended = dur == DUR_END;
endmodule
`default_nettype wire

// ----- src/fvns_ctrl.sv -----
// Sequencing controller for write, start and tick requests.
`default_nettype none
module fvns_ctrl
  import fvns_pkg::*;
#(
  parameter int VOICES = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_kind,
  input  wire sts_t       sts,
  output ctl_t            ctl,
  output logic            dec,
  output logic            start,
  output logic            emit,        // event or status ready to load
  output logic            emit_status,
  output logic            emit_playing,
  output logic            emit_finished,
  input  wire logic       out_free
);
  typedef enum logic [2:0] {
    S_IDLE, S_HDR, S_VOICE, S_NOTE, S_MATH, S_EMIT, S_STATUS
  } state_t;

  state_t     state_r;
  logic [1:0] v_r;
  logic [2:0] i_r;
  logic       phase_r;
  logic       active_r, run_r;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    ctl = '{cmd: CMD_NONE, voice: v_r, idx: i_r};
    dec = 1'b0;
    start = 1'b0;
    emit = 1'b0;
    emit_status = 1'b0;
    emit_playing = 1'b0;
    emit_finished = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_kind == KIND_WRITE) ctl.cmd = CMD_WRITE;
        if (in_valid && in_kind == KIND_START) start = 1'b1;
      end
      S_HDR: begin
        ctl.cmd = !phase_r ? CMD_RD_HDR : (i_r[0] ? CMD_HDR_HI : CMD_HDR_LO);
        ctl.idx = {2'b0, i_r[0] ^ phase_r};
        if (phase_r) ctl.idx = {2'b0, i_r[0]};
        if (!phase_r) ctl.idx = {2'b0, i_r[0]};
      end
      S_VOICE: dec = !sts.done && !sts.due;
      S_NOTE: ctl.cmd = !phase_r ? CMD_RD_NOTE : CMD_CAP_NOTE;
      S_MATH: ctl.cmd = CMD_MATH1;
      S_EMIT: if (out_free) begin
        ctl.cmd = CMD_COMMIT;
        emit = 1'b1;
      end
      S_STATUS: if (out_free) begin
        emit = 1'b1;
        emit_status = 1'b1;
        emit_playing = active_r && run_r;
        emit_finished = active_r && !run_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      v_r <= '0;
      i_r <= '0;
      phase_r <= 1'b0;
      active_r <= 1'b0;
      run_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          v_r <= '0;
          i_r <= '0;
          phase_r <= 1'b0;
          run_r <= 1'b0;
          if (in_kind == KIND_START) begin
            active_r <= 1'b1;
            if (VOICES > 0) state_r <= S_HDR;
          end else if (in_kind == KIND_TICK) begin
            state_r <= active_r ? S_VOICE : S_STATUS;
          end
        end
        S_HDR: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            i_r <= {2'b0, !i_r[0]};
            if (i_r[0]) begin
              if (32'(v_r) == VOICES - 1) state_r <= S_IDLE;
              else v_r <= v_r + 2'd1;
            end
          end
        end
        S_VOICE: begin
          if (!sts.done) run_r <= 1'b1;
          if (!sts.done && sts.due) begin
            state_r <= S_NOTE;
            i_r <= '0;
            phase_r <= 1'b0;
          end else if (32'(v_r) == VOICES - 1) state_r <= S_STATUS;
          else v_r <= v_r + 2'd1;
        end
        S_NOTE: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            if (i_r == 3'd4) state_r <= S_MATH;
            else i_r <= i_r + 3'd1;
          end
        end
        S_MATH: state_r <= S_EMIT;
        S_EMIT: if (out_free) begin
          if (32'(v_r) == VOICES - 1) state_r <= S_STATUS;
          else begin
            v_r <= v_r + 2'd1;
            state_r <= S_VOICE;
          end
        end
        S_STATUS: if (out_free) begin
          if (active_r && !run_r) active_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !in_ready) else $error("emit while idle");
  a_dec_guard: assert property (@(posedge clk) disable iff (!rst_n)
    dec |-> !sts.due) else $error("decrement at due count");
  a_status_one: assert property (@(posedge clk) disable iff (!rst_n)
    emit_status |-> !(emit_playing && emit_finished)) else $error("status both");
endmodule
`default_nettype wire

// ----- src/four_voice_note_sequencer_unit.sv -----
// Top level of the four-voice note sequencer.
// Input requests: in_tdata = {data, address}, in_tuser = kind.
//   kind 0 stores a song byte, kind 1 starts playback (reads the header
//   offsets of each voice), kind 2 is a tick, kind 3 is dropped.
// A tick yields one note event per voice whose countdown runs out, then
// a status item with out_tlast high. Writes and starts yield nothing.
// Timing: one request at a time. A start reads the header offsets voice by
// voice; a tick visits each voice and, per fetched note, does five byte
// reads from the song memory (each an address step and a capture step),
// a math step and an emit step, then emits the status item.
// The output register holds one result; when the receiver stalls the
// controller waits with the next result. Reset stops playback and clears
// voice state; song memory contents are undefined until written.
`default_nettype none
module four_voice_note_sequencer_unit
  import fvns_pkg::*;
#(
  parameter int VOICES     = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // address[12:0], data[20:13]
  input  wire logic [1:0]  in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // voice, tone, length_ms, volume, sounding,
                                       // voice_ended, playing, finished
  output logic             out_tuser,  // item_type
  output logic             out_tlast
);
  ctl_t ctl;
  sts_t sts;
  logic dec, start, emit, emit_status, emit_playing, emit_finished;
  logic [13:0] tone;
  logic [20:0] length_ms;
  logic [7:0]  volume;
  logic        sounding, voice_ended;
  logic        out_free;

  assign out_free = !out_tvalid || out_tready;

  fvns_ctrl #(.VOICES(VOICES)) u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_kind(in_tuser),
    .sts, .ctl, .dec, .start, .emit, .emit_status, .emit_playing,
    .emit_finished, .out_free
  );

  fvns_datapath #(.VOICES(VOICES)) u_dp (
    .clk, .rst_n, .ctl, .dec, .start, .wr_addr(in_tdata[12:0]),
    .wr_data(in_tdata[20:13]), .sts, .tone, .length_ms, .volume, .sounding,
    .voice_ended
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (emit) out_tvalid <= 1'b1;
    else if (out_tready) out_tvalid <= 1'b0;
    if (emit) begin
      out_tuser <= emit_status;
      out_tlast <= emit_status;
      if (emit_status)
        out_tdata <= {7'b0, emit_finished, emit_playing, 47'b0};
      else
        out_tdata <= {9'b0, voice_ended, sounding, volume, length_ms, tone,
                      ctl.voice};
    end
  end

  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tlast == out_tuser) else $error("tlast mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped");
  a_note_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[48:47] == 2'b00)
    else $error("status flags on note event");
endmodule
`default_nettype wire

// ----- verif/fvns_checker.sv -----
// Checker for the note sequencer: predicts results of accepted requests and compares them.
module fvns_checker
  import fvns_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [55:0] out_tdata,
  input  wire logic        out_tuser,
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               pending,
  output int               note_count,
  output int               status_count
);
  typedef struct {
    logic        item_type;
    logic [1:0]  voice;
    logic [13:0] tone;
    logic [20:0] length_ms;
    logic [7:0]  volume;
    logic        sounding;
    logic        voice_ended;
    logic        playing;
    logic        finished;
    logic        last;
  } seq_item_t;

  localparam int SONG_SIZE = 8192;

  logic [7:0]  song_mem [SONG_SIZE];
  logic [12:0] ptr [4];
  logic [15:0] count_left [4];
  logic        ended [4];
  logic        playing_now;
  seq_item_t   expected_items [$];

  function automatic logic [7:0] song_byte(int unsigned a);
    return song_mem[a % SONG_SIZE];
  endfunction

  function automatic seq_item_t blank_item();
    seq_item_t r;
    r = '{default: '0};
    return r;
  endfunction

  task automatic predict_request(logic [1:0] kind, logic [12:0] addr, logic [7:0] data);
    seq_item_t   r;
    bit          any_running;
    int unsigned p, dur, freq, att;
    if (kind == KIND_WRITE) begin
      song_mem[addr] = data;
    end else if (kind == KIND_START) begin
      for (int i = 0; i < 4; i++) begin
        ptr[i] = 13'((song_byte(2 * i) | (song_byte(2 * i + 1) << 8)) % SONG_SIZE);
        ended[i] = 1'b0;
        count_left[i] = '0;
      end
      playing_now = 1'b1;
    end else if (kind == KIND_TICK) begin
      if (!playing_now) begin
        r = blank_item();
        r.item_type = ITEM_STATUS;
        r.last = 1'b1;
        expected_items.push_back(r);
      end else begin
        any_running = 0;
        for (int i = 0; i < 4; i++) begin
          if (ended[i]) continue;
          any_running = 1;
          if (count_left[i] > 1) begin
            count_left[i]--;
            continue;
          end
          p = ptr[i];
          dur = song_byte(p) | (song_byte(p + 1) << 8);
          freq = ((song_byte(p + 2) & 'h3f) << 4) | (song_byte(p + 3) & 'h0f);
          att = song_byte(p + 4) & 'h0f;
          r = blank_item();
          r.item_type = ITEM_NOTE;
          r.voice = 2'(i);
          r.tone = 14'(freq * 10);
          r.length_ms = (dur == DUR_END) ? 21'd300 : 21'((dur / 3) * 50);
          r.volume = (att == 15) ? 8'd0 : 8'(255 - 2 * att);
          r.sounding = (freq != 0);
          r.voice_ended = (dur == DUR_END);
          expected_items.push_back(r);
          if (dur == DUR_END) ended[i] = 1'b1;
          count_left[i] = 16'(dur * 10 / 28);
          ptr[i] = 13'((p + 5) % SONG_SIZE);
        end
        r = blank_item();
        r.item_type = ITEM_STATUS;
        r.last = 1'b1;
        if (any_running) r.playing = 1'b1;
        else begin
          r.finished = 1'b1;
          playing_now = 1'b0;
        end
        expected_items.push_back(r);
      end
    end
  endtask

  task automatic compare_result();
    seq_item_t e, a;
    a.item_type   = out_tuser;
    a.voice       = out_tdata[1:0];
    a.tone        = out_tdata[15:2];
    a.length_ms   = out_tdata[36:16];
    a.volume      = out_tdata[44:37];
    a.sounding    = out_tdata[45];
    a.voice_ended = out_tdata[46];
    a.playing     = out_tdata[47];
    a.finished    = out_tdata[48];
    a.last        = out_tlast;
    if (expected_items.size() == 0) begin
      $error("unexpected result: type %0d voice %0d", a.item_type, a.voice);
      fail_count++;
      return;
    end
    e = expected_items.pop_front();
    if (a.item_type == ITEM_NOTE) note_count++;
    else status_count++;
    if (a.item_type != e.item_type) begin
      $error("item_type: expected %0d, got %0d", e.item_type, a.item_type); fail_count++;
    end
    if (a.voice != e.voice) begin
      $error("voice: expected %0d, got %0d", e.voice, a.voice); fail_count++;
    end
    if (a.tone != e.tone) begin
      $error("tone: expected %0d, got %0d", e.tone, a.tone); fail_count++;
    end
    if (a.length_ms != e.length_ms) begin
      $error("length_ms: expected %0d, got %0d", e.length_ms, a.length_ms); fail_count++;
    end
    if (a.volume != e.volume) begin
      $error("volume: expected %0d, got %0d", e.volume, a.volume); fail_count++;
    end
    if (a.sounding != e.sounding) begin
      $error("sounding: expected %0d, got %0d", e.sounding, a.sounding); fail_count++;
    end
    if (a.voice_ended != e.voice_ended) begin
      $error("voice_ended: expected %0d, got %0d", e.voice_ended, a.voice_ended); fail_count++;
    end
    if (a.playing != e.playing) begin
      $error("playing: expected %0d, got %0d", e.playing, a.playing); fail_count++;
    end
    if (a.finished != e.finished) begin
      $error("finished: expected %0d, got %0d", e.finished, a.finished); fail_count++;
    end
    if (a.last != e.last) begin
      $error("last: expected %0d, got %0d", e.last, a.last); fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    note_count = 0;
    status_count = 0;
    pending = 0;
    playing_now = 1'b0;
    for (int i = 0; i < SONG_SIZE; i++) song_mem[i] = '0;
    for (int i = 0; i < 4; i++) begin
      ptr[i] = '0;
      count_left[i] = '0;
      ended[i] = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      // a request's results never come out on its own accept edge
      if (in_tvalid && in_tready) predict_request(in_tuser, in_tdata[12:0], in_tdata[20:13]);
      if (out_tvalid && out_tready) compare_result();
      pending = expected_items.size();
    end
  end
endmodule

// ----- verif/tb_four_voice_note_sequencer_unit.sv -----
// Testbench top for the note sequencer: drives song writes, starts and ticks; gives the verdict.
module tb_four_voice_note_sequencer_unit;
  import fvns_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int fail_count, pending, note_count, status_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int request_count = 0;
  int song_count = 0;

  four_voice_note_sequencer_unit dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  fvns_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .fail_count, .pending, .note_count, .status_count
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver side: random stalls, plus a long hold when asked
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(logic [1:0] kind, logic [12:0] addr, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = {3'b000, data, addr};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    request_count++;
  endtask

  task automatic write_byte(int unsigned addr, logic [7:0] data);
    send_request(KIND_WRITE, 13'(addr), data);
  endtask

  task automatic write_note(int unsigned addr, logic [15:0] dur, logic [7:0] f0,
                            logic [7:0] f1, logic [7:0] vol);
    write_byte(addr, dur[7:0]);
    write_byte(addr + 1, dur[15:8]);
    write_byte(addr + 2, f0);
    write_byte(addr + 3, f1);
    write_byte(addr + 4, vol);
  endtask

  task automatic send_tick();
    send_request(KIND_TICK, 13'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Random song: header plus 1..2 notes per list, each list closed by an end note.
  task automatic random_song();
    int unsigned base, nnotes;
    logic [15:0] off, dur;
    bit          fresh;
    base = $urandom_range(8, 8000);
    off = '0;
    for (int v = 0; v < 4; v++) begin
      // later voices sometimes share the previous voice's note list
      fresh = (v == 0) || ($urandom_range(1) == 0);
      // high offset bits above the song size must wrap away
      if (fresh) off = 16'(base) | (16'($urandom_range(7)) << 13);
      write_byte(2 * v, off[7:0]);
      write_byte(2 * v + 1, off[15:8]);
      if (fresh) begin
        nnotes = $urandom_range(0, 1);
        for (int n = 0; n <= nnotes; n++) begin
          dur = (n == nnotes) ? DUR_END : 16'($urandom_range(0, 24));
          if ($urandom_range(3) == 0)
            write_note(base, dur, 8'($urandom) & 8'hc0, 8'($urandom) & 8'hf0, 8'($urandom));
          else
            write_note(base, dur, 8'($urandom), 8'($urandom), 8'($urandom));
          base += 5;
        end
      end
      if ($urandom_range(5) == 0) send_request(KIND_UNUSED, 13'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int nticks;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: idle tick, unused kind, then a song of corner notes
    send_tick();
    send_request(KIND_UNUSED, 13'h1fff, 8'hff);
    write_byte(0, 8'hfe); write_byte(1, 8'hff);     // voice 0 at 8190, wraps to 0
    write_byte(2, 8'd100); write_byte(3, 8'd0);
    write_byte(4, 8'd200); write_byte(5, 8'd0);
    write_byte(6, 8'h2c); write_byte(7, 8'h01);     // 300
    write_byte(8190, 8'hff); write_byte(8191, 8'hff);
    write_note(100, 16'd0, 8'h3f, 8'h0f, 8'h0f);
    write_note(105, DUR_END, 8'hc0, 8'hf0, 8'h00);  // rest that ends the voice
    write_note(200, 16'hfffe, 8'hff, 8'hff, 8'h00); // longest note
    write_note(300, 16'd1, 8'h01, 8'h00, 8'h0e);
    write_note(305, DUR_END, 8'h00, 8'h01, 8'hf7);
    send_request(KIND_START, 13'h0aaa, 8'h55);
    repeat (4) send_tick();
    send_request(KIND_START, 13'h1555, 8'haa);      // restart while playing
    repeat (3) send_tick();
    wait_drained();

    // random songs, cycling through idle/stall mixes
    while (song_count < 4) begin
      case (song_count % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      random_song();
      send_request(KIND_START, 13'($urandom), 8'($urandom));
      if (song_count == 1) hold_cycles = 400;  // block backs up, input stalls
      nticks = $urandom_range(5, 12);
      for (int t = 0; t < nticks; t++) begin
        send_tick();
        if ($urandom_range(30) == 0) send_request(KIND_START, 13'($urandom), 8'($urandom));
      end
      if (song_count == 2) wait_drained();
      song_count++;
    end

    in_tvalid = 1'b0;
    wait_drained();
    repeat (100) @(negedge clk);
    $display("Covered %0d requests over %0d random songs: %0d note events, %0d status items.",
             request_count, song_count, note_count, status_count);
    if (fail_count == 0 && pending == 0)
      $display("four_voice_note_sequencer_unit test passed");
    else
      $display("four_voice_note_sequencer_unit test failed");
    $finish;
  end

  initial begin
    #8000000;
    $display("four_voice_note_sequencer_unit test failed");
    $finish;
  end
endmodule

// ----- files.f -----
src/fvns_pkg.sv
src/fvns_datapath.sv
src/fvns_ctrl.sv
src/four_voice_note_sequencer_unit.sv
verif/fvns_checker.sv
verif/tb_four_voice_note_sequencer_unit.sv
